// ===== hdl/color_life_automaton_unit_macros.svh =====
// Assertion macros for the colour life unit checker.
// Depends on nets named clk and rst in the module that uses them.
`ifndef COLOR_LIFE_AUTOMATON_UNIT_MACROS_SVH
`define COLOR_LIFE_AUTOMATON_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CLAR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("colour life check failed");

// Next-cycle implication, disabled in reset
`define CLAR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("colour life check failed");

`endif

// ===== hdl/clar_pkg.sv =====
// Shared constants, codes and types for the colour life unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package clar_pkg;
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int SIZE_W     = 6;
  localparam int SUM_W      = 10;
  localparam int CNT_W      = 4;

  // divide-by-three as multiply and shift, exact for sums below 1536
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic clear;    // start a new cell
    logic take;     // accumulate memory read data
    logic is_self;  // the data is the centre cell
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/color_life_automaton_unit.sv =====
// Top level of the colour life unit: control sequencer and the two grid memories.
// Depends on clar_pkg, clar_ram and clar_cell.
//
// Colour Life on a torus of 24-bit cells held in two 1024-entry RAMs (front and
// back). One request at a time; each gives one result. After reset a clearing
// pass zeroes both grids before the first request is taken. Coordinates are
// first reduced modulo the active size by one subtraction per cycle, up to ten
// for the row and ten for the column. A write then ends in the last cycle of
// this step, and a read goes on through the registered RAM access. An advance
// walks all 1024 entries of the back grid, one RAM read per cycle: for each
// active cell nine reads, a wait for the last data, then rule and write back;
// each inactive entry is written with zero. A new request is taken no sooner
// than the cycle after the result has been accepted.
`timescale 1ns / 1ps
`default_nettype none
module color_life_automaton_unit
  import clar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic [COL_W-1:0]  col,
  input  wire logic [ROW_W-1:0]  row,
  input  wire logic [7:0]        in_red,
  input  wire logic [7:0]        in_green,
  input  wire logic [7:0]        in_blue,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        out_red,
  output logic      [7:0]        out_green,
  output logic      [7:0]        out_blue,
  output logic                   cell_alive,
  output logic      [31:0]       generation_count
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_ADV  = 3'd4;
  localparam logic [2:0] S_ADVW = 3'd5;

  logic [2:0]         state;
  logic [SIZE_W-1:0]  grid_width, grid_height;
  logic [SIZE_W-1:0]  w_eff, h_eff;
  logic               front;
  logic [31:0]        gen;
  logic [ADDR_W:0]    clr_cnt;
  logic [1:0]         act;
  logic [ROW_W-1:0]   rr, pr;
  logic [COL_W-1:0]   cc, pc;
  logic [COLOR_W-1:0] color;
  logic [3:0]         k;

  logic               cur_we, nxt_we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [COLOR_W-1:0] wdata;
  logic               a_we, b_we;
  logic [COLOR_W-1:0] qa, qb, cur_q, rule_color;
  logic               active, last_pos;
  logic [ROW_W-1:0]   up, dn, nr;
  logic [COL_W-1:0]   lf, rt, nc;
  cell_ctl_t          ctl;

  // effective grid size, clamped to 3 .. max
  always_comb begin
    w_eff = grid_width;
    if (grid_width < MIN_SIZE) w_eff = MIN_SIZE;
    else if (grid_width > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
    h_eff = grid_height;
    if (grid_height < MIN_SIZE) h_eff = MIN_SIZE;
    else if (grid_height > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(MAX_WIDTH);
      grid_height <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) grid_width <= cfg_data;
      else                        grid_height <= cfg_data;
    end
  end

  // toroidal neighbour coordinates of the current advance cell
  assign up = (pr == '0) ? ROW_W'(h_eff - SIZE_W'(1)) : pr - ROW_W'(1);
  assign dn = (SIZE_W'(pr) + SIZE_W'(1) == h_eff) ? '0 : pr + ROW_W'(1);
  assign lf = (pc == '0) ? COL_W'(w_eff - SIZE_W'(1)) : pc - COL_W'(1);
  assign rt = (SIZE_W'(pc) + SIZE_W'(1) == w_eff) ? '0 : pc + COL_W'(1);

  always_comb begin
    case (k)
      4'd0, 4'd1, 4'd2: nr = up;
      4'd6, 4'd7, 4'd8: nr = dn;
      default:          nr = pr;
    endcase
    case (k)
      4'd0, 4'd3, 4'd6: nc = lf;
      4'd2, 4'd5, 4'd8: nc = rt;
      default:          nc = pc;
    endcase
  end

  assign active   = (SIZE_W'(pr) < h_eff) && (SIZE_W'(pc) < w_eff);
  assign last_pos = (pr == '1) && (pc == '1);

  // memory port selection
  always_comb begin
    cur_we = 1'b0;
    nxt_we = 1'b0;
    waddr  = {pr, pc};
    wdata  = '0;
    raddr  = {nr, nc};
    if (state == S_CLR) begin
      waddr = clr_cnt[ADDR_W-1:0];
    end else if (state == S_MOD) begin
      waddr = {rr, cc};
      raddr = {rr, cc};
      wdata = color;
      cur_we = (act == ACT_WRITE) && (SIZE_W'(rr) < h_eff) && (SIZE_W'(cc) < w_eff);
    end else if (state == S_ADV) begin
      nxt_we = !active;
    end else if (state == S_ADVW) begin
      nxt_we = 1'b1;
      wdata  = rule_color;
    end
  end

  assign a_we  = (state == S_CLR) || (front ? nxt_we : cur_we);
  assign b_we  = (state == S_CLR) || (front ? cur_we : nxt_we);
  assign cur_q = front ? qb : qa;

  clar_ram #(.WIDTH(COLOR_W), .DEPTH(CELLS)) u_grid_a (
    .clk(clk), .we(a_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(qa)
  );

  clar_ram #(.WIDTH(COLOR_W), .DEPTH(CELLS)) u_grid_b (
    .clk(clk), .we(b_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(qb)
  );

  // accumulator control: data returned now belongs to neighbour k-1
  always_comb begin
    ctl.clear   = ((state == S_MOD) && (SIZE_W'(rr) < h_eff) && (SIZE_W'(cc) < w_eff))
                  || (state == S_ADVW) || ((state == S_ADV) && !active);
    ctl.take    = (state == S_ADV) && active && (k != '0);
    ctl.is_self = (k == 4'd5);
  end

  clar_cell u_cell (
    .clk(clk), .ctl(ctl), .rdata(cur_q), .next_color(rule_color)
  );

  assign in_ready  = (state == S_IDLE) && !out_valid;

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      front     <= 1'b0;
      gen       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + (ADDR_W+1)'(1);
          if (clr_cnt[ADDR_W]) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            act   <= action;
            rr    <= row;
            cc    <= col;
            color <= {in_red, in_green, in_blue};
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (SIZE_W'(rr) >= h_eff) begin
            rr <= ROW_W'(SIZE_W'(rr) - h_eff);
          end else if (SIZE_W'(cc) >= w_eff) begin
            cc <= COL_W'(SIZE_W'(cc) - w_eff);
          end else if (act == ACT_READ) begin
            state <= S_RDW;
          end else if (act == ACT_ADVANCE) begin
            pr    <= '0;
            pc    <= '0;
            k     <= '0;
            state <= S_ADV;
          end else begin
            out_red          <= '0;
            out_green        <= '0;
            out_blue         <= '0;
            cell_alive       <= 1'b0;
            generation_count <= gen;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_RDW: begin
          out_red          <= cur_q[23:16];
          out_green        <= cur_q[15:8];
          out_blue         <= cur_q[7:0];
          cell_alive       <= (cur_q != '0);
          generation_count <= gen;
          out_valid        <= 1'b1;
          state            <= S_IDLE;
        end
        S_ADV: begin
          if (active) begin
            k <= k + 4'd1;
            if (k == 4'd9) state <= S_ADVW;
          end
        end
        S_ADVW: begin
          // cell written back; the step below moves on
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // step to the next entry once a cell has been written back
      if ((state == S_ADVW) || ((state == S_ADV) && !active)) begin
        k <= '0;
        if (last_pos) begin
          front            <= !front;
          gen              <= gen + 32'd1;
          out_red          <= '0;
          out_green        <= '0;
          out_blue         <= '0;
          cell_alive       <= 1'b0;
          generation_count <= gen + 32'd1;
          out_valid        <= 1'b1;
          state            <= S_IDLE;
        end else begin
          pc    <= pc + COL_W'(1);
          if (pc == '1) pr <= pr + ROW_W'(1);
          state <= S_ADV;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/clar_ram.sv =====
// Generic single write port RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module clar_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/clar_cell.sv =====
// Neighbourhood accumulator and life rule for one cell.
// Depends on clar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clar_cell
  import clar_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic [COLOR_W-1:0] rdata,
  output logic      [COLOR_W-1:0] next_color
);
  logic [CNT_W-1:0]   live;
  logic [SUM_W-1:0]   sr, sg, sb;
  logic [COLOR_W-1:0] self;
  logic [2*SUM_W-1:0] qr, qg, qb;

  // gather live count and channel sums of the eight neighbours, and the centre cell
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      live <= '0;
      sr   <= '0;
      sg   <= '0;
      sb   <= '0;
      self <= '0;
    end else if (ctl.take) begin
      if (ctl.is_self) begin
        self <= rdata;
      end else if (rdata != '0) begin
        live <= live + CNT_W'(1);
        sr   <= sr + SUM_W'(rdata[23:16]);
        sg   <= sg + SUM_W'(rdata[15:8]);
        sb   <= sb + SUM_W'(rdata[7:0]);
      end
    end
  end

  // channel averages of three parents
  assign qr = sr * SUM_W'(DIV3_MUL);
  assign qg = sg * SUM_W'(DIV3_MUL);
  assign qb = sb * SUM_W'(DIV3_MUL);

  always_comb begin
    next_color = '0;
    if (self != '0) begin
      if (live == CNT_W'(2) || live == CNT_W'(3)) begin
        next_color = self;
      end
    end else if (live == CNT_W'(3)) begin
      next_color = {qr[DIV3_SHIFT +: CHAN_W], qg[DIV3_SHIFT +: CHAN_W],
                    qb[DIV3_SHIFT +: CHAN_W]};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/clar_checker.sv =====
// Port-level checks on the colour life unit, bound to the top level.
// Depends on clar_pkg and color_life_automaton_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "color_life_automaton_unit_macros.svh"
module clar_checker
  import clar_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [7:0]        out_red,
  input wire logic [7:0]        out_green,
  input wire logic [7:0]        out_blue,
  input wire logic              cell_alive,
  input wire logic [31:0]       generation_count
);
  // a waiting result stays
  `CLAR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  // a request is taken only with the result slot empty
  `CLAR_ASSERT_IMP(a_in_empty, in_valid && in_ready, !out_valid)
  // no result directly follows a delivered one
  `CLAR_ASSERT_NXT(a_out_gap, out_valid && out_ready, !out_valid)
  // a dead result cell shows black
  `CLAR_ASSERT_IMP(a_dead_black, out_valid && !cell_alive,
                   out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
endmodule

bind color_life_automaton_unit clar_checker u_clar_checker (.*);
`default_nettype wire
